[sv/adsr_envelope_per_note_defines.svh]
// Assertion macros shared by the envelope engine.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef ADSR_ENVELOPE_PER_NOTE_DEFINES_SVH
`define ADSR_ENVELOPE_PER_NOTE_DEFINES_SVH

`ifndef SYNTHESIS
`define ADSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ADSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ADSR_ASSERT_IMP(label, ante, cons, msg)
`define ADSR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[sv/adsr_env_pkg.sv]
`timescale 1ns / 1ps

package adsr_env_pkg;

    localparam int DIV_BITS  = 16;
    localparam int LVL_W     = 16;
    localparam int NOTE_W    = 7;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_PRESS    = 3'd0,
        ACT_HOLD     = 3'd1,
        ACT_RELEASE  = 3'd2,
        ACT_STILL    = 3'd3,
        ACT_IDLE     = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEAK     = 3'd0,
        REG_ATTACK   = 3'd1,
        REG_DECAY    = 3'd2,
        REG_SUSTAIN  = 3'd3,
        REG_RELEASE  = 3'd4
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] PEAK_RESET     = 16'd32768;
    localparam logic [CFG_W-1:0] LEN_RESET      = 16'd1;
    localparam logic [CFG_W-1:0] SUS_FRAC_RESET = 16'd65535;

    // One entry of the per-note store.
    typedef struct packed {
        phase_t             phase;
        logic [LVL_W-1:0]   lvl;
        logic [LVL_W-1:0]   rp;
    } ent_t;

    localparam ent_t ENT_RESET = '{phase: PH_RELEASE, lvl: '0, rp: '0};

    typedef struct packed {
        logic [CFG_W-1:0] peak;
        logic [CFG_W-1:0] attack_len;
        logic [CFG_W-1:0] decay_len;
        logic [CFG_W-1:0] sus_frac;
        logic [CFG_W-1:0] rel_len;
    } cfg_t;

    // Item context carried down the pipeline.
    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [ACT_W-1:0]  act;
        logic              rdy;
        logic              inr;
        ent_t              ent;
    } ctx_t;

    // Restoring divider state.
    typedef struct packed {
        logic [DIV_BITS-1:0] dvd;
        logic [DIV_BITS-1:0] dvs;
        logic [DIV_BITS-1:0] rem;
        logic [DIV_BITS-1:0] quo;
    } div_t;

    typedef struct packed {
        logic             we;
        ent_t             ent;
        logic [LVL_W-1:0] level;
        logic             done;
    } upd_t;

    // One quotient bit of a restoring division.
    function automatic div_t div_step(div_t d);
        logic [DIV_BITS:0] trial;
        logic [DIV_BITS:0] diff;
        div_t              r;
        r     = d;
        trial = {d.rem, d.dvd[DIV_BITS-1]};
        diff  = trial - {1'b0, d.dvs};
        r.dvd = {d.dvd[DIV_BITS-2:0], 1'b0};
        if (trial >= {1'b0, d.dvs})
        begin
            r.rem = diff[DIV_BITS-1:0];
            r.quo = {d.quo[DIV_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DIV_BITS-1:0];
            r.quo = {d.quo[DIV_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[sv/adsr_env_mem.sv]
`timescale 1ns / 1ps

// Per-note state memory with a registered read and a clearing
// sweep after reset.
module adsr_env_mem #(
    parameter int NOTES = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [((NOTES > 1) ? $clog2(NOTES) : 1)-1:0] rd_addr,
    output adsr_env_pkg::ent_t  rd_data,
    input  logic                wr_en,
    input  logic [((NOTES > 1) ? $clog2(NOTES) : 1)-1:0] wr_addr,
    input  adsr_env_pkg::ent_t  wr_data,
    output logic                clearing
);

    localparam int AW = (NOTES > 1) ? $clog2(NOTES) : 1;

    adsr_env_pkg::ent_t mem [NOTES];
    adsr_env_pkg::ent_t rd_data_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [AW-1:0]      clr_cnt_next;
    logic               clr_busy_reg;
    logic               clr_busy_next;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            if (clr_cnt_reg == AW'(NOTES - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= adsr_env_pkg::ENT_RESET;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

[sv/adsr_env_div.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, carrying the
// item context alongside. All stages move together when adv is high.
module adsr_env_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  adsr_env_pkg::ctx_t  in_ctx,
    input  adsr_env_pkg::div_t  in_div,
    output logic [adsr_env_pkg::DIV_BITS-1:0] stage_valid,
    output logic [adsr_env_pkg::NOTE_W-1:0]   stage_note [adsr_env_pkg::DIV_BITS],
    output logic                out_vld,
    output adsr_env_pkg::ctx_t  out_ctx,
    output logic [adsr_env_pkg::DIV_BITS-1:0] out_quo
);

    localparam int N = adsr_env_pkg::DIV_BITS;

    adsr_env_pkg::ctx_t ctx_reg [N];
    adsr_env_pkg::div_t div_reg [N];
    logic [N-1:0]       valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[N-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0] <= in_ctx;
            div_reg[0] <= adsr_env_pkg::div_step(in_div);
            for (int k = 1; k < N; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
                div_reg[k] <= adsr_env_pkg::div_step(div_reg[k-1]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            stage_note[k] = ctx_reg[k].note;
        end
    end

    assign stage_valid = valid_reg;
    assign out_vld     = valid_reg[N-1];
    assign out_ctx     = ctx_reg[N-1];
    assign out_quo     = div_reg[N-1].quo;

endmodule

[sv/adsr_env_upd.sv]
`timescale 1ns / 1ps

// Envelope update: turns the stored entry, the key event and the ramp step
// into the new entry and the result word.
module adsr_env_upd (
    input  adsr_env_pkg::ctx_t                ctx,
    input  logic [adsr_env_pkg::DIV_BITS-1:0] quo,
    input  adsr_env_pkg::cfg_t                cfg,
    input  logic [adsr_env_pkg::LVL_W-1:0]    sus,
    output adsr_env_pkg::upd_t                res
);

    localparam int W = adsr_env_pkg::LVL_W;

    logic [W-1:0]       amt_dec;
    logic [W-1:0]       step_att;
    logic [W-1:0]       step_dec;
    logic [W-1:0]       step_rel;
    logic [W:0]         sum_att;
    logic [W:0]         lim_dec;
    adsr_env_pkg::ent_t nx;
    logic               done;

    always_comb
    begin
        amt_dec  = cfg.peak - sus;
        // A step that truncates to zero is raised to one so no ramp stalls.
        step_att = (quo == '0 && cfg.peak != '0) ? W'(1) : quo;
        step_dec = (quo == '0 && amt_dec != '0) ? W'(1) : quo;
        step_rel = (quo == '0) ? W'(1) : quo;
        sum_att  = {1'b0, ctx.ent.lvl} + {1'b0, step_att};
        lim_dec  = {1'b0, sus} + {1'b0, step_dec};
        nx       = ctx.ent;
        done     = 1'b0;
        if (!ctx.rdy)
        begin
            nx.phase = adsr_env_pkg::PH_RELEASE;
            nx.lvl   = '0;
        end
        else
        begin
            unique case (ctx.act)
                adsr_env_pkg::ACT_PRESS:
                begin
                    nx.phase = adsr_env_pkg::PH_ATTACK;
                    nx.lvl   = step_att;
                end
                adsr_env_pkg::ACT_HOLD:
                begin
                    unique case (ctx.ent.phase)
                        adsr_env_pkg::PH_ATTACK:
                        begin
                            if (sum_att >= {1'b0, cfg.peak})
                            begin
                                nx.lvl   = cfg.peak;
                                nx.phase = adsr_env_pkg::PH_DECAY;
                            end
                            else
                            begin
                                nx.lvl = sum_att[W-1:0];
                            end
                        end
                        adsr_env_pkg::PH_DECAY:
                        begin
                            if ({1'b0, ctx.ent.lvl} <= lim_dec)
                            begin
                                nx.lvl   = sus;
                                nx.phase = adsr_env_pkg::PH_SUSTAIN;
                            end
                            else
                            begin
                                nx.lvl = ctx.ent.lvl - step_dec;
                            end
                        end
                        adsr_env_pkg::PH_SUSTAIN,
                        adsr_env_pkg::PH_RELEASE:
                        begin
                            nx.lvl   = sus;
                            nx.phase = adsr_env_pkg::PH_SUSTAIN;
                        end
                    endcase
                end
                adsr_env_pkg::ACT_RELEASE:
                begin
                    nx.phase = adsr_env_pkg::PH_RELEASE;
                    nx.rp    = ctx.ent.lvl;
                end
                adsr_env_pkg::ACT_STILL:
                begin
                    if (ctx.ent.lvl != '0)
                    begin
                        nx.lvl = (ctx.ent.lvl > step_rel) ? ctx.ent.lvl - step_rel : '0;
                    end
                    else
                    begin
                        done   = 1'b1;
                        nx.lvl = '0;
                        nx.rp  = '0;
                    end
                end
                adsr_env_pkg::ACT_IDLE:
                begin
                    nx.lvl = '0;
                end
                default:
                begin
                    nx = ctx.ent;
                end
            endcase
        end
        res.we    = ctx.inr;
        res.ent   = nx;
        res.level = ctx.inr ? nx.lvl : '0;
        res.done  = ctx.inr & done;
    end

endmodule

[sv/adsr_envelope_per_note.sv]
// Per-note ADSR envelope engine.
// Input channel (in_valid / in_ready): each word names a note, its key event
// and whether its sample is ready; the engine advances that note's envelope by
// one frame. Output channel (out_valid / out_ready): one result word per input
// word, in input order, carrying the note, its new Q0.16 level and a done flag
// that marks a finished release.
// Configuration: cfg_we writes cfg_data into register cfg_index (peak level,
// attack, decay, sustain fraction, release); write only while no word is in flight.
// From acceptance a word passes the state memory read, the pipelined divider that
// forms the ramp step, and the result register that drives out_valid.
// Words for distinct notes are accepted one per cycle unless the output stalls.
// A word for a note that is still in flight waits until that note's entry is
// written back, so a note repeated back to back waits out the whole pipeline.
// After reset the state memory is swept to release at level zero, one entry a
// cycle, across all NOTES entries; in_ready stays low during the sweep.
// When the receiver stalls, the result register holds its word and the
// pipeline keeps moving until a finished word reaches it; then the whole
// pipeline holds and in_ready drops.
`timescale 1ns / 1ps

`include "adsr_envelope_per_note_defines.svh"

module adsr_envelope_per_note #(
    parameter int NOTES = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [adsr_env_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adsr_env_pkg::CFG_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [adsr_env_pkg::NOTE_W-1:0]       note_index,
    input  logic [adsr_env_pkg::ACT_W-1:0]        action,
    input  logic                                  sample_ready,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [adsr_env_pkg::NOTE_W-1:0]       out_note,
    output logic [adsr_env_pkg::LVL_W-1:0]        level,
    output logic                                  note_done
);

    localparam int AW = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam int W  = adsr_env_pkg::LVL_W;
    localparam int DB = adsr_env_pkg::DIV_BITS;

    // Configuration registers.
    adsr_env_pkg::cfg_t cfg_reg;
    logic [W-1:0]       sus_reg;
    logic [2*W-1:0]     sus_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak       <= adsr_env_pkg::PEAK_RESET;
            cfg_reg.attack_len <= adsr_env_pkg::LEN_RESET;
            cfg_reg.decay_len  <= adsr_env_pkg::LEN_RESET;
            cfg_reg.sus_frac   <= adsr_env_pkg::SUS_FRAC_RESET;
            cfg_reg.rel_len    <= adsr_env_pkg::LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                adsr_env_pkg::REG_PEAK:    cfg_reg.peak       <= cfg_data;
                adsr_env_pkg::REG_ATTACK:  cfg_reg.attack_len <= cfg_data;
                adsr_env_pkg::REG_DECAY:   cfg_reg.decay_len  <= cfg_data;
                adsr_env_pkg::REG_SUSTAIN: cfg_reg.sus_frac   <= cfg_data;
                adsr_env_pkg::REG_RELEASE: cfg_reg.rel_len    <= cfg_data;
                default:                   cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // The sustain level follows the configuration in the next cycle; the reset sweep
    // covers it. Configuration changes only while idle is up to the user, not enforced.
    assign sus_prod = cfg_reg.peak * cfg_reg.sus_frac;

    always_ff @(posedge clk)
    begin
        sus_reg <= sus_prod[2*W-1:W];
    end

    // Pipeline control.
    logic                pipe_adv;
    logic                in_acc;
    logic                hazard;
    logic                clearing;
    logic                fin_vld;
    adsr_env_pkg::ctx_t  fin_ctx;
    logic [DB-1:0]       fin_quo;
    adsr_env_pkg::upd_t  upd;
    logic                wr_en;
    logic [DB-1:0]       stage_valid;
    logic [adsr_env_pkg::NOTE_W-1:0] stage_note [DB];
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_load;
    logic [adsr_env_pkg::NOTE_W-1:0] out_note_reg;
    logic [W-1:0]                    level_reg;
    logic                            note_done_reg;

    // The pipeline holds only when a finished word meets a full, stalled
    // result register.
    assign pipe_adv = !(fin_vld && out_valid_reg && !out_ready);
    assign in_ready = pipe_adv && !clearing && !hazard;
    assign in_acc   = in_valid && in_ready;
    assign wr_en    = fin_vld && pipe_adv && upd.we;

    // Read stage: the memory data lines up with these registers.
    logic                            st0_valid_reg;
    logic [adsr_env_pkg::NOTE_W-1:0] st0_note_reg;
    logic [adsr_env_pkg::ACT_W-1:0]  st0_act_reg;
    logic                            st0_rdy_reg;
    logic                            st0_inr_reg;
    adsr_env_pkg::ent_t              rd_ent;
    adsr_env_pkg::ctx_t              st0_ctx;
    adsr_env_pkg::div_t              st0_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st0_valid_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            st0_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            st0_note_reg <= note_index;
            st0_act_reg  <= action;
            st0_rdy_reg  <= sample_ready;
            st0_inr_reg  <= (32'(note_index) < NOTES);
        end
    end

    // Interlock: a note may not enter while an earlier word for it is in
    // flight, since its write-back has not yet happened.
    always_comb
    begin
        hazard = st0_valid_reg && (st0_note_reg == note_index);
        for (int k = 0; k < DB; k++)
        begin
            hazard = hazard || (stage_valid[k] && (stage_note[k] == note_index));
        end
    end

    adsr_env_mem #(
        .NOTES    (NOTES)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_acc),
        .rd_addr  (AW'(note_index)),
        .rd_data  (rd_ent),
        .wr_en    (wr_en),
        .wr_addr  (AW'(fin_ctx.note)),
        .wr_data  (upd.ent),
        .clearing (clearing)
    );

    // Choose the division for this word: release step when still released,
    // decay step when held in decay, attack step otherwise.
    always_comb
    begin
        st0_ctx.note = st0_note_reg;
        st0_ctx.act  = st0_act_reg;
        st0_ctx.rdy  = st0_rdy_reg;
        st0_ctx.inr  = st0_inr_reg;
        st0_ctx.ent  = rd_ent;
        st0_div.rem  = '0;
        st0_div.quo  = '0;
        if (st0_act_reg == adsr_env_pkg::ACT_STILL)
        begin
            st0_div.dvd = rd_ent.rp;
            st0_div.dvs = cfg_reg.rel_len;
        end
        else if (st0_act_reg == adsr_env_pkg::ACT_HOLD &&
                 rd_ent.phase == adsr_env_pkg::PH_DECAY)
        begin
            st0_div.dvd = cfg_reg.peak - sus_reg;
            st0_div.dvs = cfg_reg.decay_len;
        end
        else
        begin
            st0_div.dvd = cfg_reg.peak;
            st0_div.dvs = cfg_reg.attack_len;
        end
        // A zero length counts as one frame.
        if (st0_div.dvs == '0)
        begin
            st0_div.dvs = DB'(1);
        end
    end

    adsr_env_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (pipe_adv),
        .in_vld      (st0_valid_reg),
        .in_ctx      (st0_ctx),
        .in_div      (st0_div),
        .stage_valid (stage_valid),
        .stage_note  (stage_note),
        .out_vld     (fin_vld),
        .out_ctx     (fin_ctx),
        .out_quo     (fin_quo)
    );

    adsr_env_upd u_upd (
        .ctx (fin_ctx),
        .quo (fin_quo),
        .cfg (cfg_reg),
        .sus (sus_reg),
        .res (upd)
    );

    // Result register.
    assign out_load = fin_vld && pipe_adv;

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_note_reg  <= fin_ctx.note;
            level_reg     <= upd.level;
            note_done_reg <= upd.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_note  = out_note_reg;
    assign level     = level_reg;
    assign note_done = note_done_reg;

    // No word enters during the reset sweep.
    `ADSR_ASSERT_IMP(a_no_accept_clearing, in_acc, !clearing, "word accepted during clear sweep")
    // The interlock keeps a read and a write-back of the same note apart.
    `ADSR_ASSERT_IMP(a_no_rmw_overlap, in_acc && wr_en, note_index != fin_ctx.note,
                     "read and write-back of the same note overlap")
    // A finished release always reports silence.
    `ADSR_ASSERT_IMP(a_done_silent, out_valid && note_done, level == '0,
                     "note done with nonzero level")
    // The clear sweep runs once after reset and never restarts.
    `ADSR_ASSERT_NXT(a_clear_once, !clearing, !clearing, "clear sweep restarted")

endmodule
